FILE: hw/rtl/maps_pkg.sv
package maps_pkg;

  localparam int unsigned TimeW = 40;
  localparam int unsigned DurW  = 21;

  // operating modes
  localparam logic [1:0] MODE_PROFILE  = 2'd0;
  localparam logic [1:0] MODE_COOLDOWN = 2'd1;
  localparam logic [1:0] MODE_FAULT    = 2'd2;

  // fault causes
  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_ERROR    = 2'd1;
  localparam logic [1:0] CAUSE_OVERTEMP = 2'd2;
  localparam logic [1:0] CAUSE_TIMEOUT  = 2'd3;

  // input commands
  localparam logic CMD_FEEDBACK = 1'b0;
  localparam logic CMD_CONTROL  = 1'b1;

  // register indexes
  localparam logic [2:0] REG_TEMP_FAULT_LIMIT    = 3'd0;
  localparam logic [2:0] REG_COOLDOWN_ENTER_TEMP = 3'd1;
  localparam logic [2:0] REG_COOLDOWN_EXIT_TEMP  = 3'd2;
  localparam logic [2:0] REG_WARN_TEMP           = 3'd3;
  localparam logic [2:0] REG_FB_GAP_LIMIT        = 3'd4;
  localparam logic [2:0] REG_STARTUP_GRACE_MS    = 3'd5;

  localparam logic [7:0]  TEMP_FAULT_LIMIT_RST    = 8'd90;
  localparam logic [7:0]  COOLDOWN_ENTER_TEMP_RST = 8'd80;
  localparam logic [7:0]  COOLDOWN_EXIT_TEMP_RST  = 8'd65;
  localparam logic [7:0]  WARN_TEMP_RST           = 8'd70;
  localparam logic [15:0] FB_GAP_LIMIT_RST        = 16'd5000;
  localparam logic [15:0] STARTUP_GRACE_MS_RST    = 16'd10000;

  localparam logic [DurW-1:0] DUR_5_MIN  = DurW'(5 * 60 * 1000);
  localparam logic [DurW-1:0] DUR_10_MIN = DurW'(10 * 60 * 1000);
  localparam logic [DurW-1:0] DUR_20_MIN = DurW'(20 * 60 * 1000);

  localparam logic [31:0] SPEED_ZERO  = 32'h0000_0000;  // 0.0f
  localparam logic [31:0] SPEED_THREE = 32'h4040_0000;  // 3.0f
  localparam logic [31:0] SPEED_SIX   = 32'h40C0_0000;  // 6.0f

  localparam int unsigned FrameMinLen = 8;

  typedef struct packed {
    logic [7:0]  temp_fault_limit;
    logic [7:0]  cooldown_enter_temp;
    logic [7:0]  cooldown_exit_temp;
    logic [7:0]  warn_temp;
    logic [15:0] fb_gap_limit;
    logic [15:0] startup_grace_ms;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic [TimeW-1:0] now_ms;
    logic             frame_extended;
    logic [3:0]       frame_length;
    logic [63:0]      frame_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] speed_bits;
    logic [1:0]  op_mode;
    logic [2:0]  step_number;
    logic        disable_now;
    logic [1:0]  fault_cause;
    logic        temp_warning;
  } out_item_t;

  function automatic logic [31:0] plan_speed(input logic [2:0] idx);
    logic [31:0] spd;
    case (idx)
      3'd1:    spd = SPEED_THREE;
      3'd2:    spd = SPEED_SIX;
      3'd3:    spd = SPEED_THREE;
      default: spd = SPEED_ZERO;
    endcase
    return spd;
  endfunction

  function automatic logic [DurW-1:0] plan_duration(input logic [2:0] idx);
    logic [DurW-1:0] dur;
    case (idx)
      3'd1:    dur = DUR_20_MIN;
      3'd2:    dur = DUR_20_MIN;
      3'd3:    dur = DUR_10_MIN;
      default: dur = DUR_5_MIN;
    endcase
    return dur;
  endfunction

endpackage

FILE: hw/rtl/maps_cfg_regs.sv
module maps_cfg_regs
  import maps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TEMP_FAULT_LIMIT:    cfg_d.temp_fault_limit    = pwdata[7:0];
        REG_COOLDOWN_ENTER_TEMP: cfg_d.cooldown_enter_temp = pwdata[7:0];
        REG_COOLDOWN_EXIT_TEMP:  cfg_d.cooldown_exit_temp  = pwdata[7:0];
        REG_WARN_TEMP:           cfg_d.warn_temp           = pwdata[7:0];
        REG_FB_GAP_LIMIT:        cfg_d.fb_gap_limit        = pwdata[15:0];
        REG_STARTUP_GRACE_MS:    cfg_d.startup_grace_ms    = pwdata[15:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEMP_FAULT_LIMIT:    prdata = {24'd0, cfg_q.temp_fault_limit};
      REG_COOLDOWN_ENTER_TEMP: prdata = {24'd0, cfg_q.cooldown_enter_temp};
      REG_COOLDOWN_EXIT_TEMP:  prdata = {24'd0, cfg_q.cooldown_exit_temp};
      REG_WARN_TEMP:           prdata = {24'd0, cfg_q.warn_temp};
      REG_FB_GAP_LIMIT:        prdata = {16'd0, cfg_q.fb_gap_limit};
      REG_STARTUP_GRACE_MS:    prdata = {16'd0, cfg_q.startup_grace_ms};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_fault_limit    <= TEMP_FAULT_LIMIT_RST;
      cfg_q.cooldown_enter_temp <= COOLDOWN_ENTER_TEMP_RST;
      cfg_q.cooldown_exit_temp  <= COOLDOWN_EXIT_TEMP_RST;
      cfg_q.warn_temp           <= WARN_TEMP_RST;
      cfg_q.fb_gap_limit        <= FB_GAP_LIMIT_RST;
      cfg_q.startup_grace_ms    <= STARTUP_GRACE_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/motor_aging_profile_supervisor_unit.sv
// path: a control update is registered in the input register and its result in the result
//   register, from which it can transfer out
// throughput: one item per cycle; the single pass from the input register to the
//   result register (40-bit elapsed-time compares) sets the rate, feedback items never stall,
//   a control update waits while an earlier result is held by the receiver
// reset: asynchronous active low; mode, step, feedback record and fault cause clear,
//   configuration registers return to their defaults, no item is held
module motor_aging_profile_supervisor_unit
  import maps_pkg::*;
#(
  parameter int unsigned NUM_STEPS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // last step before the profile wraps to step zero
  localparam logic [2:0] LastStep = 3'(NUM_STEPS - 1);

  cfg_t cfg;

  maps_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register stage
  logic      in_vld_q;
  in_item_t  in_q;
  // result register stage
  logic      out_vld_q, out_vld_d;
  out_item_t out_q, out_d;
  // supervisor state
  logic [1:0]       run_mode_q, run_mode_d;
  logic [2:0]       step_idx_q, step_idx_d;
  logic [TimeW-1:0] step_start_q, step_start_d;
  logic             fb_valid_q, fb_valid_d;
  logic [3:0]       fb_error_q, fb_error_d;
  logic [7:0]       fb_mos_temp_q, fb_mos_temp_d;
  logic [7:0]       fb_rotor_temp_q, fb_rotor_temp_d;
  logic [TimeW-1:0] fb_time_q, fb_time_d;
  logic [1:0]       cause_q, cause_d;

  logic             advance;
  logic [TimeW-1:0] now;
  logic [7:0]       max_temp;
  logic             frame_ok;
  logic             resumed;
  logic             disable_now;
  logic             timed_out;
  logic [TimeW-1:0] step_elapsed;
  logic [TimeW-1:0] fb_elapsed;
  logic             step_done;

  // the held item moves on when it makes no result or the result slot frees up
  assign advance    = in_vld_q && (in_q.cmd == CMD_FEEDBACK || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign now      = in_q.now_ms;
  assign max_temp = (fb_mos_temp_q > fb_rotor_temp_q) ? fb_mos_temp_q : fb_rotor_temp_q;
  // standard frames with a full eight data bytes only
  assign frame_ok = !in_q.frame_extended && (in_q.frame_length >= 4'(FrameMinLen));

  // elapsed times clamp at zero when time runs backwards
  assign fb_elapsed   = (now >= fb_time_q) ? (now - fb_time_q) : '0;
  assign step_elapsed = (now >= step_start_q) ? (now - step_start_q) : '0;
  assign step_done    = step_elapsed >= TimeW'(plan_duration(step_idx_q));

  assign timed_out = fb_valid_q ? (fb_elapsed > TimeW'(cfg.fb_gap_limit))
                                : (now > TimeW'(cfg.startup_grace_ms));

  always_comb begin
    run_mode_d      = run_mode_q;
    step_idx_d      = step_idx_q;
    step_start_d    = step_start_q;
    fb_valid_d      = fb_valid_q;
    fb_error_d      = fb_error_q;
    fb_mos_temp_d   = fb_mos_temp_q;
    fb_rotor_temp_d = fb_rotor_temp_q;
    fb_time_d       = fb_time_q;
    cause_d         = cause_q;
    resumed         = 1'b0;
    disable_now     = 1'b0;
    out_d           = out_q;

    if (in_q.cmd == CMD_FEEDBACK) begin
      // record the frame: error nibble from byte 0, temperatures from bytes 6 and 7
      if (frame_ok) begin
        fb_error_d      = in_q.frame_data[63:60];
        fb_mos_temp_d   = in_q.frame_data[15:8];
        fb_rotor_temp_d = in_q.frame_data[7:0];
        fb_time_d       = now;
        fb_valid_d      = 1'b1;
      end
    end else begin
      if (run_mode_q != MODE_FAULT) begin
        // feedback checks in order of precedence
        if (fb_valid_q) begin
          if (fb_error_q != 4'd0) begin
            run_mode_d  = MODE_FAULT;
            cause_d     = CAUSE_ERROR;
            disable_now = 1'b1;
          end else if (max_temp >= cfg.temp_fault_limit) begin
            run_mode_d  = MODE_FAULT;
            cause_d     = CAUSE_OVERTEMP;
            disable_now = 1'b1;
          end else if (run_mode_q == MODE_PROFILE && max_temp >= cfg.cooldown_enter_temp) begin
            run_mode_d = MODE_COOLDOWN;
          end else if (run_mode_q == MODE_COOLDOWN && max_temp <= cfg.cooldown_exit_temp) begin
            // resuming restarts the current step
            run_mode_d   = MODE_PROFILE;
            step_start_d = now;
            resumed      = 1'b1;
          end
        end
        if (!disable_now && timed_out) begin
          run_mode_d  = MODE_FAULT;
          cause_d     = CAUSE_TIMEOUT;
          disable_now = 1'b1;
        end
        // a freshly restarted step has nothing elapsed yet
        if (!disable_now && !resumed && run_mode_d == MODE_PROFILE && step_done) begin
          step_idx_d   = (step_idx_q == LastStep) ? 3'd0 : step_idx_q + 3'd1;
          step_start_d = now;
        end
      end

      out_d.speed_bits   = (!disable_now && run_mode_d == MODE_PROFILE)
                           ? plan_speed(step_idx_d) : SPEED_ZERO;
      out_d.op_mode      = run_mode_d;
      out_d.step_number  = step_idx_d;
      out_d.disable_now  = disable_now;
      out_d.fault_cause  = (run_mode_d == MODE_FAULT) ? cause_d : CAUSE_NONE;
      out_d.temp_warning = fb_valid_q && (max_temp >= cfg.warn_temp);
    end
  end

  // result slot fills on a control update and drains on a transfer out
  always_comb begin
    if (advance && in_q.cmd == CMD_CONTROL) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
      run_mode_q      <= MODE_PROFILE;
      step_idx_q      <= 3'd0;
      step_start_q    <= '0;
      fb_valid_q      <= 1'b0;
      fb_error_q      <= 4'd0;
      fb_mos_temp_q   <= 8'd0;
      fb_rotor_temp_q <= 8'd0;
      fb_time_q       <= '0;
      cause_q         <= CAUSE_NONE;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      out_vld_q <= out_vld_d;
      if (advance) begin
        run_mode_q      <= run_mode_d;
        step_idx_q      <= step_idx_d;
        step_start_q    <= step_start_d;
        fb_valid_q      <= fb_valid_d;
        fb_error_q      <= fb_error_d;
        fb_mos_temp_q   <= fb_mos_temp_d;
        fb_rotor_temp_q <= fb_rotor_temp_d;
        fb_time_q       <= fb_time_d;
        cause_q         <= cause_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && in_q.cmd == CMD_CONTROL) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: sim/supervisor_result_checker.sv
module supervisor_result_checker
  import maps_pkg::*;
#(
  parameter int unsigned NUM_STEPS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [39:0] HOLD_5_MIN  = 40'd300_000;
  localparam logic [39:0] HOLD_10_MIN = 40'd600_000;
  localparam logic [39:0] HOLD_20_MIN = 40'd1_200_000;
  localparam logic [31:0] RAD_S_ZERO  = 32'h0000_0000;
  localparam logic [31:0] RAD_S_THREE = 32'h4040_0000;
  localparam logic [31:0] RAD_S_SIX   = 32'h40C0_0000;

  // shadow of the supervisor
  cfg_t        cfg;
  logic [1:0]  cur_mode;
  logic [2:0]  cur_step;
  logic [39:0] step_t0;
  logic        have_fb;
  logic [3:0]  fb_code;
  logic [7:0]  fb_mos;
  logic [7:0]  fb_rotor;
  logic [39:0] fb_stamp;
  logic [1:0]  trip_cause;

  out_item_t expected_updates[$];
  out_item_t oldest;

  function automatic logic [39:0] ms_since(input logic [39:0] now, input logic [39:0] then);
    return (now >= then) ? now - then : 40'd0;
  endfunction

  function automatic logic [39:0] step_hold_ms(input logic [2:0] idx);
    logic [39:0] hold;
    case (idx)
      3'd1, 3'd2: hold = HOLD_20_MIN;
      3'd3:       hold = HOLD_10_MIN;
      default:    hold = HOLD_5_MIN;
    endcase
    return hold;
  endfunction

  function automatic logic [31:0] step_speed(input logic [2:0] idx);
    logic [31:0] spd;
    case (idx)
      3'd1, 3'd3: spd = RAD_S_THREE;
      3'd2:       spd = RAD_S_SIX;
      default:    spd = RAD_S_ZERO;
    endcase
    return spd;
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    logic [31:0] val;
    case (idx)
      REG_TEMP_FAULT_LIMIT:    val = 32'(cfg.temp_fault_limit);
      REG_COOLDOWN_ENTER_TEMP: val = 32'(cfg.cooldown_enter_temp);
      REG_COOLDOWN_EXIT_TEMP:  val = 32'(cfg.cooldown_exit_temp);
      REG_WARN_TEMP:           val = 32'(cfg.warn_temp);
      REG_FB_GAP_LIMIT:        val = 32'(cfg.fb_gap_limit);
      default:                 val = 32'(cfg.startup_grace_ms);
    endcase
    return val;
  endfunction

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
    end
  endtask

  task automatic advance_supervisor(input in_item_t item);
    logic [7:0] hottest;
    logic       tripped;
    logic       stale;
    out_item_t  upd;
    hottest = (fb_mos > fb_rotor) ? fb_mos : fb_rotor;
    if (item.cmd == CMD_FEEDBACK) begin
      // extended or short frames leave the record alone
      if (!item.frame_extended && item.frame_length >= 4'd8) begin
        fb_code  = item.frame_data[63:60];
        fb_mos   = item.frame_data[15:8];
        fb_rotor = item.frame_data[7:0];
        fb_stamp = item.now_ms;
        have_fb  = 1'b1;
      end
    end else begin
      tripped = 1'b0;
      upd     = '0;
      if (cur_mode != MODE_FAULT) begin
        if (have_fb) begin
          if (fb_code != 4'd0) begin
            cur_mode   = MODE_FAULT;
            trip_cause = CAUSE_ERROR;
            tripped    = 1'b1;
          end else if (hottest >= cfg.temp_fault_limit) begin
            cur_mode   = MODE_FAULT;
            trip_cause = CAUSE_OVERTEMP;
            tripped    = 1'b1;
          end else if (cur_mode == MODE_PROFILE && hottest >= cfg.cooldown_enter_temp) begin
            cur_mode = MODE_COOLDOWN;
          end else if (cur_mode == MODE_COOLDOWN && hottest <= cfg.cooldown_exit_temp) begin
            cur_mode = MODE_PROFILE;
            step_t0  = item.now_ms;
          end
        end
        if (!tripped) begin
          stale = have_fb ? (ms_since(item.now_ms, fb_stamp) > 40'(cfg.fb_gap_limit))
                          : (item.now_ms > 40'(cfg.startup_grace_ms));
          if (stale) begin
            cur_mode   = MODE_FAULT;
            trip_cause = CAUSE_TIMEOUT;
            tripped    = 1'b1;
          end
        end
        if (!tripped && cur_mode == MODE_PROFILE) begin
          if (ms_since(item.now_ms, step_t0) >= step_hold_ms(cur_step)) begin
            cur_step = (cur_step == 3'(NUM_STEPS - 1)) ? 3'd0 : cur_step + 3'd1;
            step_t0  = item.now_ms;
          end
          upd.speed_bits = step_speed(cur_step);
        end
      end
      upd.op_mode      = cur_mode;
      upd.step_number  = cur_step;
      upd.disable_now  = tripped;
      upd.fault_cause  = (cur_mode == MODE_FAULT) ? trip_cause : CAUSE_NONE;
      upd.temp_warning = have_fb && (hottest >= cfg.warn_temp);
      expected_updates.push_back(upd);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.temp_fault_limit    = TEMP_FAULT_LIMIT_RST;
      cfg.cooldown_enter_temp = COOLDOWN_ENTER_TEMP_RST;
      cfg.cooldown_exit_temp  = COOLDOWN_EXIT_TEMP_RST;
      cfg.warn_temp           = WARN_TEMP_RST;
      cfg.fb_gap_limit        = FB_GAP_LIMIT_RST;
      cfg.startup_grace_ms    = STARTUP_GRACE_MS_RST;
      cur_mode     = MODE_PROFILE;
      cur_step     = 3'd0;
      step_t0      = '0;
      have_fb      = 1'b0;
      fb_code      = '0;
      fb_mos       = '0;
      fb_rotor     = '0;
      fb_stamp     = '0;
      trip_cause   = CAUSE_NONE;
      fail_count_o = 0;
      expected_updates.delete();
      pending_o    = 0;
    end else begin
      if (psel && penable && !pwrite && pready && paddr[4:2] <= REG_STARTUP_GRACE_MS) begin
        check_field("register readback", 64'(reg_value(paddr[4:2])), 64'(prdata));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TEMP_FAULT_LIMIT:    cfg.temp_fault_limit    = pwdata[7:0];
          REG_COOLDOWN_ENTER_TEMP: cfg.cooldown_enter_temp = pwdata[7:0];
          REG_COOLDOWN_EXIT_TEMP:  cfg.cooldown_exit_temp  = pwdata[7:0];
          REG_WARN_TEMP:           cfg.warn_temp           = pwdata[7:0];
          REG_FB_GAP_LIMIT:        cfg.fb_gap_limit        = pwdata[15:0];
          REG_STARTUP_GRACE_MS:    cfg.startup_grace_ms    = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_updates.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with none pending, expected nothing actual %0h",
                   $time, out_data_i);
        end else begin
          oldest = expected_updates.pop_front();
          check_field("speed_bits", 64'(oldest.speed_bits), 64'(out_data_i.speed_bits));
          check_field("op_mode", 64'(oldest.op_mode), 64'(out_data_i.op_mode));
          check_field("step_number", 64'(oldest.step_number), 64'(out_data_i.step_number));
          check_field("disable_now", 64'(oldest.disable_now), 64'(out_data_i.disable_now));
          check_field("fault_cause", 64'(oldest.fault_cause), 64'(out_data_i.fault_cause));
          check_field("temp_warning", 64'(oldest.temp_warning),
                      64'(out_data_i.temp_warning));
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_supervisor(in_data_i);
      end
      pending_o = expected_updates.size();
    end
  end

endmodule

FILE: sim/motor_aging_profile_supervisor_unit_tb.sv
module motor_aging_profile_supervisor_unit_tb
  import maps_pkg::*;
;

  localparam int unsigned PROFILE_STEPS  = 5;
  // longest legal quiet stretch is dominated by the receiver hold-off below
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 200;
  // lets the last item leave the input register, with margin
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASE_ITEMS    = 140;
  localparam logic [2:0]  REG_UNMAPPED   = 3'd6;
  localparam logic [39:0] TIME_MAX       = '1;
  // frame stamps this far ahead make the following updates look like time going backwards
  localparam logic [39:0] FAR_AHEAD_MS   = 40'h00_4000_0000;

  // block inputs start at known values
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_data_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  out_item_t   out_data_o;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;

  // stimulus knobs, written by the main sequence only
  int unsigned send_idle = 13;
  int unsigned recv_idle = 48;
  logic        hold_req  = 1'b0;
  // receiver side bookkeeping, written by the receiver process only
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // time base and the settings that shape well-formed sequences
  logic [39:0] now_t   = '0;
  int unsigned tmo_cur = 5000;
  int unsigned flt_lim = 90;

  int unsigned quiet_cycles = 0;

  motor_aging_profile_supervisor_unit #(
    .NUM_STEPS(PROFILE_STEPS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  supervisor_result_checker #(
    .NUM_STEPS(PROFILE_STEPS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #2 clk_i = ~clk_i;

  // receiver: random back-pressure, plus one long hold-off on request so the
  // block fills up and has to stall its input
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  // watchdog: any cycle with a transfer on either channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** motor_aging_profile_supervisor_unit: FAILED **");
      $finish;
    end
  end

  // standard frame that the block accepts; middle bytes are don't-care
  function automatic in_item_t frame_item(input logic [39:0] at, input logic [3:0] code,
                                          input logic [7:0] mos, input logic [7:0] rotor,
                                          input logic [3:0] len);
    in_item_t it;
    it.cmd            = CMD_FEEDBACK;
    it.now_ms         = at;
    it.frame_extended = 1'b0;
    it.frame_length   = len;
    it.frame_data     = {code, 44'({$urandom, $urandom}), mos, rotor};
    return it;
  endfunction

  // control update; the frame fields ride along with random content
  function automatic in_item_t update_item(input logic [39:0] at);
    in_item_t it;
    it.cmd            = CMD_CONTROL;
    it.now_ms         = at;
    it.frame_extended = 1'($urandom);
    it.frame_length   = 4'($urandom);
    it.frame_data     = {$urandom, $urandom};
    return it;
  endfunction

  // frame the block must drop: extended, or standard with fewer than 8 bytes
  function automatic in_item_t junk_item();
    in_item_t it;
    it.cmd        = CMD_FEEDBACK;
    it.now_ms     = 40'({$urandom, $urandom});
    it.frame_data = {$urandom, $urandom};
    if ($urandom_range(1, 0) == 1) begin
      it.frame_extended = 1'b1;
      it.frame_length   = 4'($urandom);
    end else begin
      it.frame_extended = 1'b0;
      it.frame_length   = 4'($urandom_range(7, 0));
    end
    return it;
  endfunction

  // temperatures stay below the fault limit so the profile keeps running
  function automatic logic [7:0] pick_temp();
    return 8'($urandom_range(flt_lim - 1, 0));
  endfunction

  function automatic logic [3:0] pick_len();
    return 4'($urandom_range(15, 8));
  endfunction

  // one input transfer; called and returning at a falling edge, valid left high
  task automatic offer(input in_item_t item);
    while ($urandom_range(99, 0) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // setup then access phase, followed by an idle phase with psel low
  task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // write, then read back a mapped register so the checker can compare it
  task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
    apb_cycle(1'b1, idx, val);
    if (idx != REG_UNMAPPED) begin
      apb_cycle(1'b0, idx, '0);
    end
  endtask

  task automatic configure(input int unsigned hot_lim, input int unsigned cool_in,
                           input int unsigned cool_out, input int unsigned warn_at,
                           input int unsigned tmo, input int unsigned grace);
    program_reg(REG_TEMP_FAULT_LIMIT, hot_lim);
    program_reg(REG_COOLDOWN_ENTER_TEMP, cool_in);
    program_reg(REG_COOLDOWN_EXIT_TEMP, cool_out);
    program_reg(REG_WARN_TEMP, warn_at);
    program_reg(REG_FB_GAP_LIMIT, tmo);
    program_reg(REG_STARTUP_GRACE_MS, grace);
    flt_lim = hot_lim;
    tmo_cur = tmo;
  endtask

  // stop offering, let every expected update arrive, then let a trailing
  // feedback item settle
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // random traffic: mostly a frame followed by a few updates inside the timeout,
  // sometimes a far-future frame with long strides that walk the step table,
  // sometimes a dropped frame or an update stamped in the past
  task automatic run_phase(input int unsigned quota);
    int unsigned done;
    int unsigned burst;
    int unsigned pick;
    done = 0;
    while (done < quota) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        offer(junk_item());
      end else if (pick < 22) begin
        offer(frame_item(now_t + FAR_AHEAD_MS, 4'd0, pick_temp(), pick_temp(), pick_len()));
        done++;
        burst = $urandom_range(3, 1);
        repeat (burst) begin
          now_t += 40'($urandom_range(1_300_000, 50_000));
          offer(update_item(now_t));
          done++;
        end
      end else begin
        offer(frame_item(now_t, 4'd0, pick_temp(), pick_temp(), pick_len()));
        done++;
        burst = $urandom_range(4, 1);
        repeat (burst) begin
          if ($urandom_range(9, 0) == 0 && now_t > 40'd3000) begin
            offer(update_item(now_t - 40'($urandom_range(3000, 1))));
          end else begin
            now_t += 40'($urandom_range(tmo_cur / 5, 0));
            offer(update_item(now_t));
          end
          done++;
        end
      end
    end
  endtask

  initial begin
    in_item_t   it;
    logic [1:0] fault_kind;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part on reset settings
    // update before any frame, well inside the startup grace
    offer(update_item(40'd0));
    // dropped frames at the field extremes
    it                = '0;
    it.cmd            = CMD_FEEDBACK;
    it.now_ms         = TIME_MAX;
    it.frame_extended = 1'b1;
    it.frame_length   = 4'hF;
    it.frame_data     = '1;
    offer(it);
    it.now_ms         = '0;
    it.frame_extended = 1'b0;
    it.frame_length   = 4'd7;
    it.frame_data     = '0;
    offer(it);
    it.frame_length   = 4'd0;
    it.frame_data     = '1;
    offer(it);
    // exactly at the startup grace: no timeout yet
    offer(update_item(40'd10_000));
    // warm motor raises the warning flag
    offer(frame_item(40'd10_100, 4'd0, 8'd72, 8'd60, 4'd8));
    offer(update_item(40'd10_200));
    // rotor at the cooldown threshold enters cooldown
    offer(frame_item(40'd10_300, 4'd0, 8'd10, 8'd80, 4'd15));
    offer(update_item(40'd10_400));
    // back down to the exit threshold resumes and restarts the step
    offer(frame_item(40'd10_500, 4'd0, 8'd65, 8'd3, 4'd8));
    offer(update_item(40'd10_600));
    // stamped before the step start: nothing elapsed
    offer(update_item(40'd10_550));
    // frame at the top of time, so later updates never see a timeout
    offer(frame_item(TIME_MAX, 4'd0, 8'd0, 8'd0, 4'd9));
    // walk the whole table, first one ms short of the step and then on it
    now_t = 40'd310_599;
    offer(update_item(now_t));
    now_t += 40'd1;
    offer(update_item(now_t));
    now_t += 40'd1_200_000;
    offer(update_item(now_t));
    now_t += 40'd1_200_000;
    offer(update_item(now_t));
    now_t += 40'd600_000;
    offer(update_item(now_t));
    now_t += 40'd300_000;
    offer(update_item(now_t));
    offer(update_item(now_t - 40'd610_600));
    now_t += 40'd300_000;
    offer(update_item(now_t));
    wait_quiet();

    // sender idles lightly, receiver heavily; wide thresholds, warning always on
    configure(255, 200, 120, 0, 65535, 0);
    run_phase(PHASE_ITEMS);
    wait_quiet();

    // roles swapped; hysteresis flips on every update, warning never
    send_idle = 48;
    recv_idle = 13;
    configure(250, 0, 255, 255, 40000, 65535);
    run_phase(PHASE_ITEMS);
    wait_quiet();

    // no idling, random thresholds, one long receiver hold-off
    send_idle = 0;
    recv_idle = 0;
    program_reg(REG_UNMAPPED, $urandom);
    configure($urandom_range(255, 200), $urandom_range(255, 0), $urandom_range(255, 0),
              $urandom_range(255, 0), $urandom_range(65535, 20000), $urandom_range(65535, 0));
    hold_req = 1'b1;
    run_phase(PHASE_ITEMS);
    wait_quiet();

    // end with one latched fault; the seed picks the cause
    fault_kind = 2'($urandom_range(3, 1));
    case (fault_kind)
      CAUSE_ERROR: begin
        // error nibble wins even over a hot motor
        offer(frame_item(now_t, 4'($urandom_range(15, 1)), 8'($urandom), 8'($urandom),
                         pick_len()));
      end
      CAUSE_OVERTEMP: begin
        program_reg(REG_TEMP_FAULT_LIMIT, 32'd0);
        offer(frame_item(now_t, 4'd0, 8'($urandom), 8'($urandom), pick_len()));
      end
      default: begin
        program_reg(REG_FB_GAP_LIMIT, 32'd0);
        offer(frame_item(now_t, 4'd0, pick_temp(), pick_temp(), pick_len()));
      end
    endcase
    // the first update trips, the rest must hold the fault without a new disable
    repeat (3) begin
      now_t += 40'($urandom_range(20_000, 1));
      offer(update_item(now_t));
    end
    offer(junk_item());
    now_t += 40'($urandom_range(20_000, 1));
    offer(update_item(now_t));
    wait_quiet();

    if (fail_count == 0) begin
      $display("** motor_aging_profile_supervisor_unit: PASSED **");
    end else begin
      $display("** motor_aging_profile_supervisor_unit: FAILED **");
    end
    $finish;
  end

endmodule
